// File: hw/rtl/mkdlp_pkg.sv
package mkdlp_pkg;

  localparam int KEYS        = 4;
  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int KEY_W       = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int CMP_W       = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  localparam int IN_BITS     = KEYS;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 + 2 * KEY_W + KEYS;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = CFG_IDX_W'(1);

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = CFG_WIDTH'(50);
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = CFG_WIDTH'(2000);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    logic stable;
    logic fire;
    logic short_cand;
  } key_status_t;

endpackage

// File: hw/rtl/mkdlp_key.sv
module mkdlp_key (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tick,
  input  logic                            pressed,
  input  logic [mkdlp_pkg::CFG_WIDTH-1:0] debounce_ticks,
  input  logic [mkdlp_pkg::CFG_WIDTH-1:0] long_press_ticks,
  input  logic                            short_take,
  output mkdlp_pkg::key_status_t          status
);
  import mkdlp_pkg::*;

  logic                   last_raw;
  logic [COUNT_WIDTH-1:0] since_change;
  logic                   stable_pressed;
  logic [COUNT_WIDTH-1:0] held_ticks;
  logic                   long_done;
  logic                   short_done;

  logic                   last_raw_next;
  logic [COUNT_WIDTH-1:0] since_change_next;
  logic                   stable_pressed_next;
  logic [COUNT_WIDTH-1:0] held_ticks_next;
  logic                   long_done_next;
  logic                   short_done_next;

  logic [COUNT_WIDTH-1:0] held_inc;
  logic                   accepted;
  logic                   press_edge;
  logic                   release_edge;
  logic                   long_tmp;
  logic                   short_tmp;
  logic                   fire;
  logic                   cand;

  always_comb begin
    last_raw_next     = pressed;
    since_change_next = (pressed != last_raw) ? '0 :
                        (since_change == CNT_MAX) ? CNT_MAX : since_change + 1'b1;
    held_inc          = (held_ticks == CNT_MAX) ? CNT_MAX : held_ticks + 1'b1;
    accepted          = CMP_W'(since_change_next) >= CMP_W'(debounce_ticks);
    press_edge        = accepted && pressed && !stable_pressed;
    release_edge      = accepted && !pressed && stable_pressed;
    held_ticks_next   = press_edge ? '0 : held_inc;
    long_tmp          = (press_edge || release_edge) ? 1'b0 : long_done;
    short_tmp         = release_edge ? 1'b0 : short_done;
    stable_pressed_next = accepted ? pressed : stable_pressed;
    fire              = accepted && pressed && !long_tmp &&
                        (CMP_W'(held_ticks_next) >= CMP_W'(long_press_ticks));
    long_done_next    = long_tmp || fire;
    cand              = stable_pressed_next && !short_tmp && !long_done_next &&
                        (CMP_W'(held_ticks_next) < CMP_W'(long_press_ticks));
    short_done_next   = short_tmp || (cand && short_take);
  end

  assign status.stable     = stable_pressed_next;
  assign status.fire       = fire;
  assign status.short_cand = cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw       <= 1'b0;
      since_change   <= '0;
      stable_pressed <= 1'b0;
      held_ticks     <= '0;
      long_done      <= 1'b0;
      short_done     <= 1'b0;
    end else if (tick) begin
      last_raw       <= last_raw_next;
      since_change   <= since_change_next;
      stable_pressed <= stable_pressed_next;
      held_ticks     <= held_ticks_next;
      long_done      <= long_done_next;
      short_done     <= short_done_next;
    end
  end

endmodule

// File: hw/rtl/multi_key_debounce_long_press.sv
// channel   dir  handshake                        payload
// s_axis    in   s_axis_tvalid / s_axis_tready    raw_levels per tick
// m_axis    out  m_axis_tvalid / m_axis_tready    short/long events, stable mask
// cfg       in   cfg_valid / cfg_ready            cfg_index, cfg_data
//
// one tick per cycle unless m_axis stalls; each result is registered at accept
// the per-key counter update and compares finish in the accepting cycle
// a tick is taken whenever the result register is empty or drained in that cycle
// rst clears all key state and m_axis_tvalid, and loads default thresholds
// cfg_ready is always high
module multi_key_debounce_long_press (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mkdlp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // raw_levels
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // short_valid, short_key, long_valid, long_key, stable_mask
  output logic [mkdlp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mkdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mkdlp_pkg::CFG_WIDTH-1:0]    cfg_data
);
  import mkdlp_pkg::*;

  logic [CFG_WIDTH-1:0] debounce_ticks;
  logic [CFG_WIDTH-1:0] long_press_ticks;

  logic                 tick;
  key_status_t          status [KEYS];
  logic [KEYS-1:0]      short_take;

  logic                 short_valid_next;
  logic [KEY_W-1:0]     short_key_next;
  logic                 long_valid_next;
  logic [KEY_W-1:0]     long_key_next;
  logic [KEYS-1:0]      mask_next;

  logic                 short_valid;
  logic [KEY_W-1:0]     short_key;
  logic                 long_valid;
  logic [KEY_W-1:0]     long_key;
  logic [KEYS-1:0]      stable_mask;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign tick          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RESET;
      long_press_ticks <= LONG_PRESS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DEBOUNCE) begin
        debounce_ticks <= cfg_data;
      end
      if (cfg_index == REG_LONG_PRESS) begin
        long_press_ticks <= cfg_data;
      end
    end
  end

  for (genvar k = 0; k < KEYS; k++) begin : g_key
    mkdlp_key u_key (
      .clk              (clk),
      .rst              (rst),
      .tick             (tick),
      .pressed          (!s_axis_tdata[k]),
      .debounce_ticks   (debounce_ticks),
      .long_press_ticks (long_press_ticks),
      .short_take       (short_take[k]),
      .status           (status[k])
    );
  end

  always_comb begin
    short_valid_next = 1'b0;
    short_key_next   = '0;
    long_valid_next  = 1'b0;
    long_key_next    = '0;
    short_take       = '0;
    mask_next        = '0;
    for (int i = 0; i < KEYS; i++) begin
      mask_next[i] = status[i].stable;
      if (status[i].fire) begin
        long_valid_next = 1'b1;
        long_key_next   = KEY_W'(i);
      end
    end
    for (int i = KEYS - 1; i >= 0; i--) begin
      if (status[i].short_cand) begin
        short_valid_next = 1'b1;
        short_key_next   = KEY_W'(i);
      end
    end
    if (short_valid_next) begin
      short_take[short_key_next] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (tick) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      short_valid <= short_valid_next;
      short_key   <= short_key_next;
      long_valid  <= long_valid_next;
      long_key    <= long_key_next;
      stable_mask <= mask_next;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'({stable_mask, long_key, long_valid, short_key, short_valid});

  a_long_pressed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && long_valid |-> stable_mask[long_key])
    else $error("long press on a key not held");

  a_short_pressed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && short_valid |-> stable_mask[short_key])
    else $error("short press on a key not held");

  a_not_both: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && short_valid && long_valid |-> short_key != long_key)
    else $error("same key reported short and long");

  a_idle_keys: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !short_valid && !long_valid |-> short_key == '0 && long_key == '0)
    else $error("key index without event");

endmodule
